/* rtl/campwm_pkg.sv */
// Package for the centre-aligned motor PWM block.
// Holds operation codes, register indexes, scaling constants and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package campwm_pkg;

    // Operation carried with each input item
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SET_PCT  = 3'd1,
        OP_SET_BYTE = 3'd2,
        OP_GET_PCT  = 3'd3,
        OP_GET_BYTE = 3'd4
    } campwm_op_t;

    // Configuration register indexes
    localparam logic REG_TOP  = 1'b0;
    localparam logic REG_CHAN = 1'b1;

    // Channel select code for "no channel driven"
    localparam logic [1:0] CHAN_NONE = 2'd0;

    // Widths of the fixed fields
    localparam int CFG_DATA_W = 16;
    localparam int DUTY_W     = 8;
    localparam int OP_W       = 3;

    // Reset value of the turning value register
    localparam logic [CFG_DATA_W-1:0] TOP_RESET = 16'd1000;

    // Percent scale, also used as its clamp, and the 8-bit readback limit
    localparam logic [DUTY_W-1:0] PCT_SCALE = 8'd100;
    localparam logic [DUTY_W-1:0] BYTE_MAX  = 8'd255;

    // Divide by 100 as multiply by ceil(2^30 / 100) and shift by 30;
    // exact for every product below 2^23 (duty 0..100 times a 16-bit top)
    localparam int                     PCT_RECIP_W = 24;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP   = 24'd10737419;
    localparam int                     PCT_SHIFT   = 30;

    // Controller state
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } campwm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_now;   // item accepted, completes this cycle
        logic accept_div;   // item accepted, needs the divider
        logic finish;       // divider result ready, commit it
    } campwm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_div;    // item on the input needs a division
        logic div_done;     // divider has a quotient
    } campwm_stat_t;

endpackage

`default_nettype wire

/* rtl/campwm_div.sv */
// Sequential restoring divider, one quotient bit per cycle.
// Standalone; used by the PWM datapath for scaling.
`timescale 1ns / 1ps
`default_nettype none

module campwm_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    // Control and payload next values
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/campwm_dp.sv */
// Datapath of the PWM block: config registers, up/down counter, compare
// buffers and active compares, duty scaling and the result register.
// Depends on campwm_pkg and campwm_div.
`timescale 1ns / 1ps
`default_nettype none

module campwm_dp
    import campwm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]       op_in,
    input  wire logic [DUTY_W-1:0]     duty_in,
    input  wire campwm_cmd_t           cmd,
    output campwm_stat_t               stat,
    output logic [2:0]                 out_pins,
    output logic [DUTY_W-1:0]          out_rd
);

    localparam int CW    = COUNT_WIDTH;
    localparam int NUM_W = COUNT_WIDTH + DUTY_W;
    localparam int PCT_W = NUM_W + PCT_RECIP_W;

    logic [CW-1:0]     top_reg;
    logic [1:0]        sel_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              down_reg, down_next;
    logic [CW-1:0]     buf_reg [3];
    logic [CW-1:0]     act_reg [3];
    logic              reload;
    campwm_op_t        op_reg;
    logic [2:0]        out_pins_reg, out_pins_next;
    logic [DUTY_W-1:0] out_rd_reg, out_rd_next;
    logic [NUM_W-1:0]  pct_x_reg;
    logic              pct_run_reg, pct_run_next;

    campwm_op_t        op;
    logic              chan_on;
    logic [1:0]        chan_idx;
    logic [CW-1:0]     buf_sel;
    logic [DUTY_W-1:0] duty_clamp;
    logic [DUTY_W-1:0] mul_a;
    logic [CW-1:0]     mul_b;
    logic [NUM_W-1:0]  prod;
    logic [NUM_W-1:0]  dividend;
    logic [CW-1:0]     divisor;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  quotient;
    logic [DUTY_W-1:0] rd_sat;
    logic [PCT_W-1:0]  pct_prod;
    logic [CW-1:0]     pct_quo;
    logic [2:0]        pins_now, pins_tick;

    assign op       = campwm_op_t'(op_in);
    assign chan_on  = (sel_reg != CHAN_NONE);
    assign chan_idx = sel_reg - 2'd1;
    assign buf_sel  = buf_reg[chan_idx];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= TOP_RESET[CW-1:0];
            sel_reg <= CHAN_NONE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_TOP:  top_reg <= cfg_data[CW-1:0];
                REG_CHAN: sel_reg <= cfg_data[1:0];
                default:  ;
            endcase
        end
    end

    // Division needed: a percent write or a read, each with a channel; reads also need a non-zero top
    always_comb
    begin
        stat.needs_div = 1'b0;
        case (op) inside
            OP_SET_PCT:               stat.needs_div = chan_on;
            OP_GET_PCT, OP_GET_BYTE:  stat.needs_div = chan_on && (top_reg != '0);
            default:                  stat.needs_div = 1'b0;
        endcase
        stat.div_done = div_done || pct_run_reg;
    end

    // Shared scaling multiplier and divider operands
    always_comb
    begin
        duty_clamp = (duty_in > PCT_SCALE) ? PCT_SCALE : duty_in;
        mul_a      = PCT_SCALE;
        mul_b      = buf_sel;
        dividend   = '0;
        divisor    = top_reg;
        case (op)
            OP_SET_PCT:
            begin
                mul_a = duty_clamp;
                mul_b = top_reg;
            end
            OP_SET_BYTE:
            begin
                mul_a = duty_in;
                mul_b = top_reg;
            end
            default: ;
        endcase
        prod = NUM_W'(mul_a) * NUM_W'(mul_b);
        if (op == OP_GET_BYTE)
            dividend = {buf_sel, {DUTY_W{1'b0}}};
        else
            dividend = prod;
    end

    // Only reads divide by the turning value
    assign div_start    = cmd.accept_div && (op != OP_SET_PCT);
    assign pct_run_next = cmd.accept_div && (op == OP_SET_PCT);

    campwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Percent write: registered product divided by 100 via reciprocal
    assign pct_prod = PCT_W'(pct_x_reg) * PCT_W'(PCT_RECIP);
    assign pct_quo  = pct_prod[PCT_SHIFT +: CW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pct_run_reg <= 1'b0;
        else
            pct_run_reg <= pct_run_next;
    end

    // 8-bit readback saturates at full scale
    assign rd_sat = (|quotient[NUM_W-1:DUTY_W]) ? BYTE_MAX : quotient[DUTY_W-1:0];

    // Counter step for a tick
    always_comb
    begin
        count_next = count_reg;
        down_next  = down_reg;
        reload     = 1'b0;
        if (!down_reg && (count_reg < top_reg))
        begin
            count_next = count_reg + 1'b1;
            down_next  = (count_next >= top_reg);
        end
        else
        begin
            down_next = 1'b1;
            if (count_reg != '0)
                count_next = count_reg - 1'b1;
            if (count_next == '0)
            begin
                down_next = 1'b0;
                reload    = 1'b1;
            end
        end
    end

    // Pin levels, before and after a tick
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pins_now[i]  = (sel_reg == 2'(i + 1)) && (count_reg < act_reg[i]);
            pins_tick[i] = (sel_reg == 2'(i + 1)) &&
                           (count_next < (reload ? buf_reg[i] : act_reg[i]));
        end
    end

    // Counter, direction and compares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            down_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                buf_reg[i] <= '0;
                act_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept_now && (op == OP_TICK))
            begin
                count_reg <= count_next;
                down_reg  <= down_next;
                if (reload)
                    for (int i = 0; i < 3; i++)
                        act_reg[i] <= buf_reg[i];
            end
            if (cmd.accept_now && (op == OP_SET_BYTE) && chan_on)
                buf_reg[chan_idx] <= prod[NUM_W-1:DUTY_W];
            if (cmd.finish && (op_reg == OP_SET_PCT))
                buf_reg[chan_idx] <= pct_quo;
        end
    end

    // Result register
    always_comb
    begin
        out_pins_next = out_pins_reg;
        out_rd_next   = out_rd_reg;
        if (cmd.accept_now)
        begin
            out_pins_next = (op == OP_TICK) ? pins_tick : pins_now;
            out_rd_next   = '0;
        end
        else if (cmd.finish)
        begin
            out_pins_next = pins_now;
            out_rd_next   = (op_reg == OP_SET_PCT) ? '0 : rd_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pins_reg <= out_pins_next;
        out_rd_reg   <= out_rd_next;
        if (cmd.accept_div)
        begin
            op_reg    <= op;
            pct_x_reg <= prod;
        end
    end

    assign out_pins = out_pins_reg;
    assign out_rd   = out_rd_reg;

endmodule

`default_nettype wire

/* rtl/campwm_ctrl.sv */
// Controller of the PWM block: input/output handshakes, sequencing of
// divider operations and the result valid flag. Depends on campwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module campwm_ctrl
    import campwm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire campwm_stat_t stat,
    output campwm_cmd_t       cmd
);

    campwm_state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                accept   = in_valid && in_ready;
                if (accept && stat.needs_div)
                begin
                    cmd.accept_div = 1'b1;
                    state_next     = ST_DIV;
                end
                else if (accept)
                    cmd.accept_now = 1'b1;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Result valid: set on completion, cleared when taken
        if (cmd.accept_now || cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/center_aligned_motor_pwm.sv */
// Top level of the centre-aligned motor PWM timer.
// Depends on campwm_pkg, campwm_ctrl, campwm_dp (and campwm_div inside it).
//
//   Channel  Direction  Handshake                     Contents
//   s_axis   in         s_axis_tvalid/s_axis_tready   op in tuser, duty in tdata
//   m_axis   out        m_axis_tvalid/m_axis_tready   pins and readback in tdata
//   cfg      in         cfg_valid/cfg_ready           register index and data
//
// Ticks, 8-bit writes and ops that need no scaling load the output
// register as soon as they are taken, so ticks can run every clock while the
// result side keeps up. Percent writes register the product, then divide
// by 100 with a reciprocal multiply. Reads go through the bit-serial
// divider. No new item is taken meanwhile. The output register is refilled
// in the cycle it is read. Reset is asynchronous, active low; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module center_aligned_motor_pwm
    import campwm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] duty_value
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // [2:0] op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [0] pin_a, [1] pin_b,
                                                       // [2] pin_c, [10:3] read_duty
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    campwm_cmd_t       cmd;
    campwm_stat_t      stat;
    logic [2:0]        pins;
    logic [DUTY_W-1:0] rd;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    campwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    campwm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_in     (s_axis_tuser),
        .duty_in   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_pins  (pins),
        .out_rd    (rd)
    );

    // Result item packing
    assign m_axis_tdata = {5'b0, rd, pins};

endmodule

`default_nettype wire

/* tb/sv/tb_center_aligned_motor_pwm.sv */
// Self-checking testbench for the centre-aligned motor PWM timer.
// Drives duty/tick items and register writes, predicts pins and readback.
// Depends on campwm_pkg and center_aligned_motor_pwm.
`timescale 1ns / 1ps

module tb_center_aligned_motor_pwm;
    import campwm_pkg::*;

    localparam int COUNT_W     = 16;
    localparam int DIV_LATENCY = COUNT_W + 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 47;

    // Channel select codes beyond "none"
    localparam logic [1:0] CHAN_A = 2'd1;
    localparam logic [1:0] CHAN_B = 2'd2;
    localparam logic [1:0] CHAN_C = 2'd3;

    // Spare op codes, expected to behave as no-ops
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Duty scales
    localparam int unsigned PCT_FULL  = 100;
    localparam int unsigned BYTE_FULL = 256;
    localparam int unsigned READ_MAX  = 255;

    localparam int unsigned COUNT_MASK = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic       pin_a;
        logic       pin_b;
        logic       pin_c;
        logic [7:0] read_duty;
    } pwm_out_t;

    // Timer state, its prediction of each output item and the results still due
    class pwm_tracker;
        logic [15:0] top_reg;
        logic [1:0]  chan;
        logic [15:0] count;
        bit          down;
        logic [15:0] buf_cmp [3];
        logic [15:0] act_cmp [3];
        pwm_out_t    pending_outputs [$];
        int          mismatch_count;

        function new();
            top_reg = TOP_RESET;
            chan    = CHAN_NONE;
            count   = '0;
            down    = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                buf_cmp[i] = '0;
                act_cmp[i] = '0;
            end
            mismatch_count = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == REG_TOP)
                top_reg = value;
            else
                chan = value[1:0];
        endfunction

        function int unsigned turn_value();
            return top_reg & COUNT_MASK;
        endfunction

        // One counter step: up to top, then down, reload compares at the bottom
        function void step_counter();
            int unsigned top;
            top = turn_value();
            if (!down && count < top)
            begin
                count = 16'((count + 1) & COUNT_MASK);
                if (count >= top)
                    down = 1'b1;
            end
            else
            begin
                down = 1'b1;
                if (count > 0)
                    count = count - 16'd1;
                if (count == 0)
                begin
                    down = 1'b0;
                    for (int i = 0; i < 3; i++)
                        act_cmp[i] = buf_cmp[i];
                end
            end
        endfunction

        // Buffer scaled back to a duty, saturated to 8 bits
        function logic [7:0] scaled_duty(int unsigned scale);
            int unsigned top;
            int unsigned v;
            top = turn_value();
            if (chan == CHAN_NONE || top == 0)
                return 8'd0;
            v = (int'(buf_cmp[chan - 1]) * scale) / top;
            return (v > READ_MAX) ? 8'(READ_MAX) : v[7:0];
        endfunction

        function void take_item(logic [2:0] op, logic [7:0] duty);
            pwm_out_t    res;
            int unsigned d;
            int unsigned top;
            res = '0;
            top = turn_value();
            d   = duty;
            case (op)
                OP_TICK:
                    step_counter();
                OP_SET_PCT:
                begin
                    if (d > PCT_FULL)
                        d = PCT_FULL;
                    if (chan != CHAN_NONE)
                        buf_cmp[chan - 1] = 16'((d * top / PCT_FULL) & COUNT_MASK);
                end
                OP_SET_BYTE:
                    if (chan != CHAN_NONE)
                        buf_cmp[chan - 1] = 16'((d * top / BYTE_FULL) & COUNT_MASK);
                OP_GET_PCT:
                    res.read_duty = scaled_duty(PCT_FULL);
                OP_GET_BYTE:
                    res.read_duty = scaled_duty(BYTE_FULL);
                default: ;
            endcase
            // pins follow the state after the op
            res.pin_a = (chan == CHAN_A) && (count < act_cmp[0]);
            res.pin_b = (chan == CHAN_B) && (count < act_cmp[1]);
            res.pin_c = (chan == CHAN_C) && (count < act_cmp[2]);
            pending_outputs.push_back(res);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_output(logic [15:0] data);
            pwm_out_t want;
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: output item with none due, expected nothing actual %h",
                         $time, data);
                return;
            end
            want = pending_outputs.pop_front();
            compare_field("pin_a", 8'(want.pin_a), 8'(data[0]));
            compare_field("pin_b", 8'(want.pin_b), 8'(data[1]));
            compare_field("pin_c", 8'(want.pin_c), 8'(data[2]));
            compare_field("read_duty", want.read_duty, data[10:3]);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] duty_value
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] pin_a, [1] pin_b, [2] pin_c, [10:3] read_duty
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = 1'b0;
    logic [15:0] cfg_data      = '0;

    bit          no_idle = 1'b0;
    pwm_tracker  tracker = new();

    center_aligned_motor_pwm #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // Present one item and hold it until taken
    task automatic send_item(logic [2:0] op, logic [7:0] duty);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= duty;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_item(op, duty);
    endtask

    task automatic send_random_item();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            op = OP_TICK;
        else if (pick < 90)
            op = OP_SET_PCT;
        else if (pick < 94)
            op = OP_SET_BYTE;
        else if (pick < 97)
            op = OP_GET_PCT;
        else
            op = OP_GET_BYTE;
        send_item(op, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Both registers, written only once the block has gone idle
    task automatic configure(logic [15:0] top, logic [1:0] chan);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= REG_TOP;
        cfg_data  <= top;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(REG_TOP, top);
        cfg_index <= REG_CHAN;
        cfg_data  <= 16'(chan);
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(REG_CHAN, 16'(chan));
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls between items
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            tracker.check_output(m_axis_tdata);
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] top_val;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no channel after reset: writes dropped, reads zero, spare ops inert
        send_item(OP_TICK, 8'd0);
        send_item(OP_SET_PCT, 8'd50);
        send_item(OP_GET_PCT, 8'd0);
        send_item(OP_GET_BYTE, 8'd0);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_item(3'(op), 8'hFF);

        // smallest top: percent clamp, 8-bit read saturation, zero duty
        configure(16'd100, CHAN_A);
        send_item(OP_SET_PCT, 8'd255);
        send_item(OP_GET_PCT, 8'd0);
        send_item(OP_GET_BYTE, 8'd0);
        send_item(OP_SET_BYTE, 8'd255);
        send_item(OP_GET_BYTE, 8'd0);
        send_item(OP_SET_BYTE, 8'd0);
        send_item(OP_GET_PCT, 8'd0);
        send_item(OP_SET_PCT, 8'd100);

        // largest top
        configure(16'hFFFF, CHAN_B);
        send_item(OP_SET_BYTE, 8'd255);
        send_item(OP_GET_BYTE, 8'd0);
        send_item(OP_SET_PCT, 8'd100);
        send_item(OP_GET_PCT, 8'd0);
        send_item(OP_TICK, 8'd0);

        // top lowered under a full buffer: both reads saturate
        configure(16'd100, CHAN_B);
        send_item(OP_GET_BYTE, 8'd0);
        send_item(OP_GET_PCT, 8'd0);

        configure(16'd100, CHAN_C);
        send_item(OP_SET_PCT, 8'd37);
        send_item(OP_TICK, 8'd0);

        // random phases, mostly small tops so the counter turns and reloads
        for (int phase = 0; phase < PHASES; phase++)
        begin
            no_idle = (phase % 3 == 2);
            case (phase)
                0:       top_val = 16'hFFFF;
                1:       top_val = 16'd100;
                5:       top_val = 16'($urandom_range(100, 65535));
                default: top_val = 16'($urandom_range(100, 120));
            endcase
            configure(top_val, 2'((phase + 1) % 4));
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain_outputs();
        repeat (2 * DIV_LATENCY) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending_outputs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/campwm_pkg.sv
rtl/campwm_div.sv
rtl/campwm_dp.sv
rtl/campwm_ctrl.sv
rtl/center_aligned_motor_pwm.sv
tb/sv/tb_center_aligned_motor_pwm.sv
